/* src/olist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Ordered list engine package
// Shared sizes, operation and status codes, and the command and status
// words that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package olist_pkg;

   // Store size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   // Field widths of the request and response words.
   localparam int OP_W  = 3;
   localparam int FLD_W = 7;
   localparam int ST_W  = 3;
   localparam int CNT_W = 7;

   // Width that holds both a position and a length plus one without overflow.
   localparam int CMP_W = ((LEN_W > FLD_W) ? LEN_W : FLD_W) + 1;

   // Largest value the store accepts.
   localparam logic [FLD_W-1:0] MAX_VALUE = FLD_W'(100);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_DELETE = OP_W'(1);
   localparam logic [OP_W-1:0] OP_FILTER = OP_W'(2);
   localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(3);
   localparam logic [OP_W-1:0] OP_READ   = OP_W'(4);

   // Status codes.
   localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
   localparam logic [ST_W-1:0] ST_BAD_VALUE = ST_W'(1);
   localparam logic [ST_W-1:0] ST_BAD_POS   = ST_W'(2);
   localparam logic [ST_W-1:0] ST_EMPTY     = ST_W'(3);
   localparam logic [ST_W-1:0] ST_FULL      = ST_W'(4);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } olist_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } olist_stat_type;

endpackage
`default_nettype wire

/* src/olist_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Ordered list engine channels
// Request and response channels with a valid/ready handshake; a word moves
// at a rising edge where valid and ready are both high.
// ---------------------------------------------------------------------------
interface olist_req_if;
   import olist_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [FLD_W-1:0] position;
   logic [FLD_W-1:0] value;
   logic [FLD_W-1:0] threshold;

   modport source (output valid, output opcode, output position, output value,
                   output threshold, input ready);
   modport sink   (input valid, input opcode, input position, input value,
                   input threshold, output ready);
endinterface

interface olist_rsp_if;
   import olist_pkg::*;

   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [CNT_W-1:0] count;
   logic [FLD_W-1:0] read_value;

   modport source (output valid, output status, output count, output read_value,
                   input ready);
   modport sink   (input valid, input status, input count, input read_value,
                   output ready);
endinterface
`default_nettype wire

/* src/ordered_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Ordered list engine
// Ordered store of small values edited by positional insert, delete,
// threshold filter, clear and read requests; one response word per request.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one request word (opcode, position, value, threshold);
//   rsp_chan returns exactly one word (status, count, read_value) for it.
//   Requests are handled one at a time. After a word is accepted the block
//   scans the entry memory, one entry per cycle through its single read
//   port and single write port, then writes the response register.
//   Each request touches N entries: length - position + 1 for insert,
//   length - position for delete, length for filter and one for read;
//   N is zero for clear, a rejected request and an insert at the tail.
//   req_chan.ready rises in the cycle the response word becomes valid.
//   If rsp_chan stalls, the next request finishes its scan and then
//   holds until the waiting word is taken.
//   Reset empties the list (length zero); memory contents are left as is.
// ---------------------------------------------------------------------------
module ordered_list_engine (
   input wire logic   clock,
   input wire logic   reset,
   olist_req_if.sink  req_chan,
   olist_rsp_if.source rsp_chan
);
   import olist_pkg::*;

   olist_cmd_type  cmd;
   olist_stat_type stat;

   // Request sequencing.
   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, checks and response register.
   olist_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_chan.opcode),
      .req_position   (req_chan.position),
      .req_value      (req_chan.value),
      .req_threshold  (req_chan.threshold),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_status     (rsp_chan.status),
      .rsp_count      (rsp_chan.count),
      .rsp_read_value (rsp_chan.read_value)
   );

`ifndef SYNTHESIS
   // Only one request is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while another is in work");

   // A read value is only returned by a successful read.
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.read_value != '0) |-> rsp_chan.status == ST_OK)
      else $error("nonzero read value with error status");

   // Status is always a defined code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.status <= ST_FULL)
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire

/* src/olist_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Ordered list engine controller
// Sequences one request at a time: accept, scan the store, then post the
// response word into the output register.
// ---------------------------------------------------------------------------
module olist_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  olist_pkg::olist_stat_type     stat,
   output olist_pkg::olist_cmd_type      cmd
);
   import olist_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;

   // A new word is taken only between requests.
   assign req_ready = (state_ff == S_IDLE);

   // Commands follow directly from the state, gated by req_valid and out_free.
   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && req_valid;
      cmd.step   = (state_ff == S_SCAN);
      cmd.finish = (state_ff == S_FINISH) && stat.out_free;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/olist_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Ordered list engine datapath
// Holds the entry memory, the length, the request checks, the scan pointers
// that shift or compact entries one per cycle, and the response register.
// ---------------------------------------------------------------------------
module olist_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  olist_pkg::olist_cmd_type              cmd,
   output olist_pkg::olist_stat_type             stat,
   input  wire logic [olist_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [olist_pkg::FLD_W-1:0]      req_position,
   input  wire logic [olist_pkg::FLD_W-1:0]      req_value,
   input  wire logic [olist_pkg::FLD_W-1:0]      req_threshold,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic [olist_pkg::ST_W-1:0]            rsp_status,
   output logic [olist_pkg::CNT_W-1:0]           rsp_count,
   output logic [olist_pkg::FLD_W-1:0]           rsp_read_value
);
   import olist_pkg::*;

   typedef enum logic [2:0] {
      PLAN_NONE,
      PLAN_INS,
      PLAN_DEL,
      PLAN_FILT,
      PLAN_CLR,
      PLAN_READ
   } plan_type;

   // Entry memory and its registered read data.
   logic [FLD_W-1:0] mem_ff [CAPACITY];
   logic [FLD_W-1:0] rd_data_ff;
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [FLD_W-1:0] wr_data;

   // Control registers.
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Request and scan registers.
   plan_type         plan_ff, plan_in;
   logic [ST_W-1:0]  stat_ff, stat_in;
   logic [FLD_W-1:0] pos_ff, pos_in;
   logic [FLD_W-1:0] val_ff, val_in;
   logic [FLD_W-1:0] thr_ff, thr_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] raddr_ff, raddr_in;
   logic [LEN_W-1:0] kept_ff, kept_in;
   logic [ST_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [FLD_W-1:0] rsp_value_ff, rsp_value_in;

   // Request check results.
   plan_type         ld_plan;
   logic [ST_W-1:0]  ld_stat;
   logic [IDX_W-1:0] ld_ptr;
   logic [LEN_W-1:0] ld_rem;
   logic [CMP_W-1:0] len_w;
   logic [CMP_W-1:0] pos_w;

   assign len_w = CMP_W'(len_ff);
   assign pos_w = CMP_W'(req_position);

   // Status back to the controller.
   assign stat.scan_done = (rem_ff == '0) && !pend_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_value_ff;

   // Check the incoming request and plan its scan: start index and number of reads.
   always_comb begin
      ld_plan = PLAN_NONE;
      ld_stat = ST_OK;
      ld_ptr  = '0;
      ld_rem  = '0;
      case (req_opcode)
         OP_INSERT: begin
            if (req_value > MAX_VALUE) begin
               ld_stat = ST_BAD_VALUE;
            end else if (pos_w == '0 || pos_w > len_w + CMP_W'(1)) begin
               ld_stat = ST_BAD_POS;
            end else if (len_w == CMP_W'(CAPACITY)) begin
               ld_stat = ST_FULL;
            end else begin
               // Shift entries from the tail down to the insert point.
               ld_plan = PLAN_INS;
               ld_ptr  = IDX_W'(len_w - CMP_W'(1));
               ld_rem  = LEN_W'(len_w + CMP_W'(1) - pos_w);
            end
         end
         OP_DELETE: begin
            if (len_w == '0) begin
               ld_stat = ST_EMPTY;
            end else if (pos_w == '0 || pos_w > len_w) begin
               ld_stat = ST_BAD_POS;
            end else begin
               // Shift the entries after the removed one down by one.
               ld_plan = PLAN_DEL;
               ld_ptr  = IDX_W'(pos_w);
               ld_rem  = LEN_W'(len_w - pos_w);
            end
         end
         OP_FILTER: begin
            if (len_w == '0) begin
               ld_stat = ST_EMPTY;
            end else begin
               ld_plan = PLAN_FILT;
               ld_rem  = len_ff;
            end
         end
         OP_CLEAR: begin
            ld_plan = PLAN_CLR;
         end
         OP_READ: begin
            if (len_w == '0) begin
               ld_stat = ST_EMPTY;
            end else if (pos_w == '0 || pos_w > len_w) begin
               ld_stat = ST_BAD_POS;
            end else begin
               ld_plan = PLAN_READ;
               ld_ptr  = IDX_W'(pos_w - CMP_W'(1));
               ld_rem  = LEN_W'(1);
            end
         end
         default: begin
            ld_plan = PLAN_NONE;
         end
      endcase
   end

   // Next-state logic for load, scan and finish.
   always_comb begin
      len_in        = len_ff;
      rem_in        = rem_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      plan_in       = plan_ff;
      stat_in       = stat_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      thr_in        = thr_ff;
      ptr_in        = ptr_ff;
      raddr_in      = raddr_ff;
      kept_in       = kept_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;

      // Latch the request and its plan.
      if (cmd.load) begin
         plan_in = ld_plan;
         stat_in = ld_stat;
         pos_in  = req_position;
         val_in  = req_value;
         thr_in  = req_threshold;
         ptr_in  = ld_ptr;
         rem_in  = ld_rem;
         pend_in = 1'b0;
         kept_in = '0;
      end

      // One read issued per cycle; the earlier read is written back for insert, delete and kept filter entries.
      if (cmd.step) begin
         pend_in = (rem_ff != '0);
         if (rem_ff != '0) begin
            rd_en    = 1'b1;
            raddr_in = ptr_ff;
            rem_in   = rem_ff - LEN_W'(1);
            if (plan_ff == PLAN_INS) begin
               ptr_in = ptr_ff - IDX_W'(1);
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         if (pend_ff) begin
            case (plan_ff)
               PLAN_INS: begin
                  wr_en   = 1'b1;
                  wr_addr = raddr_ff + IDX_W'(1);
               end
               PLAN_DEL: begin
                  wr_en   = 1'b1;
                  wr_addr = raddr_ff - IDX_W'(1);
               end
               PLAN_FILT: begin
                  // Keep entries below the threshold, packed from the front.
                  if (rd_data_ff < thr_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = IDX_W'(kept_ff);
                     kept_in = kept_ff + LEN_W'(1);
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
      end

      // Response word and length update.
      if (cmd.finish) begin
         rsp_status_in = stat_ff;
         rsp_count_in  = CNT_W'(len_ff);
         rsp_value_in  = '0;
         case (plan_ff)
            PLAN_INS: begin
               wr_en        = 1'b1;
               wr_addr      = IDX_W'(pos_ff - FLD_W'(1));
               wr_data      = val_ff;
               len_in       = len_ff + LEN_W'(1);
               rsp_count_in = CNT_W'(len_ff + LEN_W'(1));
            end
            PLAN_DEL: begin
               len_in       = len_ff - LEN_W'(1);
               rsp_count_in = CNT_W'(len_ff - LEN_W'(1));
            end
            PLAN_FILT: begin
               len_in       = kept_ff;
               rsp_count_in = CNT_W'(len_ff - kept_ff);
            end
            PLAN_CLR: begin
               len_in = '0;
            end
            PLAN_READ: begin
               rsp_value_in = rd_data_ff;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end

      // The output register fills on finish and drains when the word is taken.
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      plan_ff       <= plan_in;
      stat_ff       <= stat_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      thr_ff        <= thr_in;
      ptr_ff        <= ptr_in;
      raddr_ff      <= raddr_in;
      kept_ff       <= kept_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[ptr_ff];
      end
   end

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered list engine testbench
// Drives insert, delete, filter, clear and read requests through the request
// channel. A checker object keeps its own copy of the ordered store and
// predicts one response word per accepted request. Every response word is
// compared field by field with the oldest prediction. The run goes through
// four phases with different rates of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
module testbench;
   import olist_pkg::*;

   localparam int FLD_MAX     = (2 ** FLD_W) - 1;
   localparam int OP_LAST     = (2 ** OP_W) - 1;
   localparam int PHASE_WORDS = 330;
   localparam int BURST_WORDS = 30;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [FLD_W-1:0] position;
      logic [FLD_W-1:0] value;
      logic [FLD_W-1:0] threshold;
   } list_request_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] count;
      logic [FLD_W-1:0] read_value;
   } list_response_type;

   // Request mixes: mostly growing, balanced, or mostly shrinking the list.
   typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} traffic_mix_type;

   // Holds a private copy of the ordered store and the responses still due.
   class ordered_list_checker;
      logic [FLD_W-1:0]  store[CAPACITY];
      int                list_len = 0;
      int                errors = 0;
      list_response_type pending_responses[$];

      function int pending();
         return pending_responses.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
         end
      endtask

      // Applies an accepted request to the store and queues its response.
      function void note_request(list_request_type rq);
         list_response_type rsp;
         int                kept;
         int                pos;
         pos = int'(rq.position);
         rsp.status = ST_OK;
         rsp.read_value = '0;
         rsp.count = CNT_W'(list_len);
         case (rq.opcode)
            OP_INSERT: begin
               // The value is checked before the position, then the room.
               if (rq.value > MAX_VALUE) begin
                  rsp.status = ST_BAD_VALUE;
               end else if (pos == 0 || pos > list_len + 1) begin
                  rsp.status = ST_BAD_POS;
               end else if (list_len >= CAPACITY) begin
                  rsp.status = ST_FULL;
               end else begin
                  for (int i = list_len; i >= pos; i--) store[i] = store[i-1];
                  store[pos-1] = rq.value;
                  list_len++;
               end
               rsp.count = CNT_W'(list_len);
            end
            OP_DELETE: begin
               if (list_len == 0) begin
                  rsp.status = ST_EMPTY;
               end else if (pos == 0 || pos > list_len) begin
                  rsp.status = ST_BAD_POS;
               end else begin
                  for (int i = pos - 1; i + 1 < list_len; i++) store[i] = store[i+1];
                  list_len--;
               end
               rsp.count = CNT_W'(list_len);
            end
            OP_FILTER: begin
               // Keep entries below the threshold, in order; count the rest.
               if (list_len == 0) begin
                  rsp.status = ST_EMPTY;
                  rsp.count = '0;
               end else begin
                  kept = 0;
                  for (int i = 0; i < list_len; i++) begin
                     if (store[i] < rq.threshold) begin
                        store[kept] = store[i];
                        kept++;
                     end
                  end
                  rsp.count = CNT_W'(list_len - kept);
                  list_len = kept;
               end
            end
            OP_CLEAR: begin
               rsp.count = CNT_W'(list_len);
               list_len = 0;
            end
            OP_READ: begin
               if (list_len == 0) begin
                  rsp.status = ST_EMPTY;
               end else if (pos == 0 || pos > list_len) begin
                  rsp.status = ST_BAD_POS;
               end else begin
                  rsp.read_value = store[pos-1];
               end
               rsp.count = CNT_W'(list_len);
            end
            default: begin
               rsp.count = CNT_W'(list_len);
            end
         endcase
         pending_responses.push_back(rsp);
      endfunction

      // Compares one response word with the oldest prediction.
      task check_response(logic [ST_W-1:0] status, logic [CNT_W-1:0] count,
                          logic [FLD_W-1:0] read_value);
         list_response_type want;
         if (pending_responses.size() == 0) begin
            report($sformatf("unexpected word status=%0d count=%0d read_value=%0d",
                             status, count, read_value));
            return;
         end
         want = pending_responses.pop_front();
         if (status !== want.status) begin
            report($sformatf("status %0d, predicted %0d", status, want.status));
         end
         if (count !== want.count) begin
            report($sformatf("count %0d, predicted %0d", count, want.count));
         end
         if (read_value !== want.read_value) begin
            report($sformatf("read_value %0d, predicted %0d", read_value,
                             want.read_value));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 0;
   int   stall_pct = 0;

   ordered_list_checker list_check = new;

   olist_req_if req_chan();
   olist_rsp_if rsp_chan();

   ordered_list_engine u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response side: check each accepted word, then pick the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         list_check.check_response(rsp_chan.status, rsp_chan.count, rsp_chan.read_value);
      end
      rsp_chan.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Sends one request word and returns at the edge where it is accepted.
   // Valid is left high; the next call or a pause decides its next value.
   task automatic send_word(logic [OP_W-1:0] op, logic [FLD_W-1:0] pos,
                            logic [FLD_W-1:0] val, logic [FLD_W-1:0] thr);
      list_request_type rq;
      rq.opcode = op;
      rq.position = pos;
      rq.value = val;
      rq.threshold = thr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= rq.opcode;
      req_chan.position <= rq.position;
      req_chan.value <= rq.value;
      req_chan.threshold <= rq.threshold;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      list_check.note_request(rq);
   endtask

   // Lowers valid and holds off until every response has come back.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (list_check.pending() != 0);
   endtask

   // One random request, mostly well formed for the current list length.
   task automatic send_random(traffic_mix_type mix);
      int               len;
      int               roll;
      int               cut[5];
      logic [OP_W-1:0]  op;
      logic [FLD_W-1:0] pos;
      logic [FLD_W-1:0] val;
      logic [FLD_W-1:0] thr;
      len = list_check.list_len;
      roll = $urandom_range(99);
      case (mix)
         MIX_GROW:  cut = '{75, 83, 93, 96, 97};
         MIX_CHURN: cut = '{40, 65, 85, 92, 95};
         default:   cut = '{15, 55, 75, 93, 97};
      endcase
      if (roll < cut[0]) begin
         op = OP_INSERT;
      end else if (roll < cut[1]) begin
         op = OP_DELETE;
      end else if (roll < cut[2]) begin
         op = OP_READ;
      end else if (roll < cut[3]) begin
         op = OP_FILTER;
      end else if (roll < cut[4]) begin
         op = OP_CLEAR;
      end else begin
         op = OP_W'($urandom_range(OP_LAST, OP_READ + 1));
      end
      pos = FLD_W'($urandom_range(FLD_MAX));
      val = FLD_W'($urandom_range(FLD_MAX));
      thr = FLD_W'($urandom_range(FLD_MAX));
      // Nine in ten requests carry legal values and positions.
      if ($urandom_range(9) != 0) begin
         val = FLD_W'($urandom_range(MAX_VALUE));
         thr = FLD_W'($urandom_range(MAX_VALUE + 1, MAX_VALUE / 3));
         if (op == OP_INSERT) begin
            pos = FLD_W'($urandom_range(len + 1, 1));
         end else if (len > 0) begin
            pos = FLD_W'($urandom_range(len, 1));
         end
      end
      send_word(op, pos, val, thr);
   endtask

   // Fills the store, then pushes inserts and edits at the full boundary.
   task automatic fill_store();
      while (list_check.list_len < CAPACITY) begin
         send_word(OP_INSERT, FLD_W'($urandom_range(list_check.list_len + 1, 1)),
                   FLD_W'($urandom_range(MAX_VALUE)), FLD_W'($urandom_range(FLD_MAX)));
      end
      repeat (3) begin
         send_word(OP_INSERT, FLD_W'($urandom_range(CAPACITY + 1, 1)),
                   FLD_W'($urandom_range(MAX_VALUE)), '0);
      end
      send_word(OP_READ, FLD_W'(CAPACITY), '0, '0);
      send_word(OP_DELETE, FLD_W'(CAPACITY), '0, '0);
      send_word(OP_INSERT, FLD_W'(CAPACITY), MAX_VALUE, '0);
   endtask

   // Run limit.
   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Reset, directed requests, then the random phases.
   initial begin
      int sent;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_INSERT;
      req_chan.position = '0;
      req_chan.value = '0;
      req_chan.threshold = '0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Requests on an empty store.
      send_word(OP_READ, 7'd1, '0, '0);
      send_word(OP_DELETE, 7'd1, '0, '0);
      send_word(OP_FILTER, '0, '0, 7'd50);
      send_word(OP_CLEAR, '0, '0, '0);
      // Insert errors: value first, then position.
      send_word(OP_INSERT, 7'd1, MAX_VALUE + 7'd1, '0);
      send_word(OP_INSERT, '0, '1, '0);
      send_word(OP_INSERT, '0, 7'd5, '0);
      send_word(OP_INSERT, 7'd2, 7'd5, '0);
      // Build the list 50, 0, 7, 100 through front, middle and end inserts.
      send_word(OP_INSERT, 7'd1, '0, '0);
      send_word(OP_INSERT, 7'd2, MAX_VALUE, '0);
      send_word(OP_INSERT, 7'd1, 7'd50, '0);
      send_word(OP_INSERT, 7'd3, 7'd7, '0);
      send_word(OP_READ, '0, '0, '0);
      send_word(OP_READ, 7'd5, '0, '0);
      send_word(OP_READ, 7'd4, '0, '0);
      send_word(OP_READ, 7'd1, '0, '0);
      send_word(OP_DELETE, '0, '0, '0);
      send_word(OP_DELETE, '1, '0, '0);
      send_word(OP_DELETE, 7'd2, '0, '0);
      // Unused opcodes leave the store alone.
      for (int op = OP_READ + 1; op <= OP_LAST; op++) begin
         send_word(OP_W'(op), '1, '1, '1);
      end
      // Filters that remove nothing, some, and everything.
      send_word(OP_FILTER, '0, '0, '1);
      send_word(OP_FILTER, '0, '0, 7'd50);
      send_word(OP_FILTER, '0, '0, '0);
      send_word(OP_INSERT, 7'd1, 7'd9, '0);
      send_word(OP_CLEAR, '0, '0, '0);

      // Random phases, each ending in a full store and a drained pipeline.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 49;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 49;
            end
            default: begin
               send_idle_pct = 36;
               stall_pct = 36;
            end
         endcase
         sent = 0;
         while (sent < PHASE_WORDS) begin
            traffic_mix_type mix;
            mix = traffic_mix_type'($urandom_range(MIX_SHRINK));
            repeat (BURST_WORDS) send_random(mix);
            sent += BURST_WORDS;
         end
         fill_store();
         drain_responses();
      end

      repeat (CAPACITY + 8) @(posedge clock);
      if (list_check.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
